### src/bfsc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Bitmap find / set / clear engine package
// Request and result payload types, word operation control shared by the
// engine and its word operation unit, and the engine state encoding.
// ----------------------------------------------------------------------------
package bfsc_pkg;

  localparam logic [31:0] ALL_ONES = 32'hFFFF_FFFF;

  typedef enum logic [1:0] {
    REQ_FIND_SET    = 2'd0,
    REQ_FIND_ZERO   = 2'd1,
    REQ_SET_RANGE   = 2'd2,
    REQ_CLEAR_RANGE = 2'd3
  } bfsc_req_t;

  typedef struct packed {
    bfsc_req_t   req_type;
    logic [14:0] start_bit;
    logic [15:0] bit_count;
  } bfsc_in_t;

  typedef struct packed {
    logic        found;
    logic [14:0] bit_position;
    logic [15:0] bits_changed;
  } bfsc_out_t;

  // Control for one word: request kind, first bit offset (MSB-first) and
  // the offset one past the last bit of the run within the word (1..32).
  typedef struct packed {
    bfsc_req_t   kind;
    logic [4:0]  offset;
    logic [5:0]  stop;
  } bfsc_word_ctrl_t;

  typedef struct packed {
    logic        hit;
    logic [4:0]  lead;
    logic [31:0] new_word;
  } bfsc_word_res_t;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_RUN,
    ST_DONE
  } bfsc_state_t;

endpackage
`default_nettype wire

### src/bfsc_word_op.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Bitmap word operation unit
// Works on one 32-bit bitmap word: finds the first matching bit at or after
// an offset, and forms the word with a run of bits set or cleared.
// ----------------------------------------------------------------------------
module bfsc_word_op
  import bfsc_pkg::*;
(
  input  wire logic [31:0]     word_i,
  input  wire bfsc_word_ctrl_t ctrl_i,
  output bfsc_word_res_t       res_o
);

  // Leading zero count by binary halving; the word is known to be nonzero
  // wherever the count is used.
  function automatic logic [4:0] lead_zeros(input logic [31:0] v);
    logic [31:0] x;
    logic [4:0]  n;
    x = v;
    n = '0;
    if (x[31:16] == 16'd0) begin
      n[4] = 1'b1;
      x    = {x[15:0], 16'd0};
    end
    if (x[31:24] == 8'd0) begin
      n[3] = 1'b1;
      x    = {x[23:0], 8'd0};
    end
    if (x[31:28] == 4'd0) begin
      n[2] = 1'b1;
      x    = {x[27:0], 4'd0};
    end
    if (x[31:30] == 2'd0) begin
      n[1] = 1'b1;
      x    = {x[29:0], 2'd0};
    end
    if (!x[31]) begin
      n[0] = 1'b1;
    end
    return n;
  endfunction

  logic [31:0] hi_mask;
  logic [31:0] lo_mask;
  logic [31:0] run_mask;
  logic [31:0] find_v;

  always_comb begin
    hi_mask  = ALL_ONES >> ctrl_i.offset;
    lo_mask  = ctrl_i.stop[5] ? 32'd0 : (ALL_ONES >> ctrl_i.stop[4:0]);
    run_mask = hi_mask & ~lo_mask;
    find_v   = ((ctrl_i.kind == REQ_FIND_ZERO) ? ~word_i : word_i) & hi_mask;

    res_o.hit  = |find_v;
    res_o.lead = lead_zeros(find_v);
    if (ctrl_i.kind == REQ_SET_RANGE) begin
      res_o.new_word = word_i | run_mask;
    end else begin
      res_o.new_word = word_i & ~run_mask;
    end
  end

endmodule
`default_nettype wire

### src/bitmap_find_set_clear_engine.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Bitmap find / set / clear engine
// Allocation bitmap in a single-port-write, single-port-read memory, walked
// one 32-bit word per cycle for finds and for set or clear runs.
// ----------------------------------------------------------------------------
// Usage:
// The request channel (in_valid, in_stall, in_data) carries one item per
// request; the engine holds in_stall high while it works, so one request is
// in flight at a time. The result channel (out_valid, out_stall, out_data)
// is fed from an output register, so a new request is taken while an
// earlier result still waits for the receiver. While out_stall is high the
// result is held unchanged, and a finished request waits in its done state
// until the output register is free.
// A request is walked through the bitmap words it visits in the run state,
// one word per cycle as the memory gives them through its read port, then
// waits in the done state until its result enters the output register, and
// the engine goes back to idle, where it can take the next request. A request
// that starts past the region or sets or clears no bits skips the walk and
// goes from acceptance straight to the done state.
// After reset the engine sweeps the whole store to zero, one word a cycle,
// with in_stall high. The region register (cfg_*) is always ready and resets
// to 1024 words.
// ----------------------------------------------------------------------------
module bitmap_find_set_clear_engine
  import bfsc_pkg::*;
#(
  parameter int BITMAP_WORDS = 1024
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire bfsc_in_t    in_data,
  output logic             out_valid,
  input  wire logic        out_stall,
  output bfsc_out_t        out_data,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [10:0] cfg_data
);

  localparam int AW = (BITMAP_WORDS > 1) ? $clog2(BITMAP_WORDS) : 1;

  // Bitmap store and its ports.
  logic [31:0]   mem [BITMAP_WORDS];
  logic [31:0]   rd_data_r;
  logic [AW-1:0] rd_addr;
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [31:0]   mem_wdata;

  // Control and request state.
  bfsc_state_t   state_r, state_nxt;
  logic [AW-1:0] clr_addr_r;
  logic [10:0]   region_r;
  bfsc_req_t     kind_r, kind_nxt;
  logic [14:0]   start_r, start_nxt;
  logic [15:0]   end_r, end_nxt;
  logic [10:0]   nwords_r, nwords_nxt;
  logic [10:0]   cur_r, cur_nxt;
  logic          first_r, first_nxt;
  bfsc_out_t     res_r, res_nxt;
  logic          out_valid_r;
  bfsc_out_t     out_data_r;

  // Request decode at acceptance.
  logic          in_acc;
  logic [10:0]   nwords_c;
  logic [15:0]   total_c;
  logic [16:0]   sum_c;
  logic [15:0]   end_c;
  logic          is_range_c;
  logic          empty_c;

  // Per-word decisions while walking.
  logic          is_range;
  logic [15:0]   diff;
  logic          run_last;
  logic          scan_last;
  logic          finish;
  logic          out_load;
  logic          clr_last;

  bfsc_word_ctrl_t wctrl;
  bfsc_word_res_t  wres;

  bfsc_word_op u_word_op (
    .word_i (rd_data_r),
    .ctrl_i (wctrl),
    .res_o  (wres)
  );

  assign in_acc     = in_valid && !in_stall;
  assign cfg_ready  = 1'b1;
  assign out_valid  = out_valid_r;
  assign out_data   = out_data_r;
  assign clr_last   = (clr_addr_r == AW'(BITMAP_WORDS - 1));

  // A region larger than the store is cut down to the store. The run end is
  // clamped to the region end, and an empty run or a start past the region
  // goes straight to a zero result.
  always_comb begin
    nwords_c   = (32'(region_r) > 32'(BITMAP_WORDS)) ? 11'(BITMAP_WORDS) : region_r;
    total_c    = {nwords_c, 5'd0};
    sum_c      = {2'b00, in_data.start_bit} + {1'b0, in_data.bit_count};
    end_c      = (sum_c > {1'b0, total_c}) ? total_c : sum_c[15:0];
    is_range_c = (in_data.req_type == REQ_SET_RANGE) ||
                 (in_data.req_type == REQ_CLEAR_RANGE);
    empty_c    = ({1'b0, in_data.start_bit} >= total_c) ||
                 (is_range_c && (in_data.bit_count == 16'd0));
  end

  // The word under examination is cur_r, whose data sits in rd_data_r. The
  // start offset applies to the first word only; for a run, the distance
  // from this word's first bit to the run end decides how much of it is
  // written and whether it is the last word.
  always_comb begin
    is_range    = (kind_r == REQ_SET_RANGE) || (kind_r == REQ_CLEAR_RANGE);
    diff        = end_r - {cur_r, 5'd0};
    run_last    = (diff <= 16'd32);
    scan_last   = ({1'b0, cur_r} + 12'd1) >= {1'b0, nwords_r};
    wctrl.kind   = kind_r;
    wctrl.offset = first_r ? start_r[4:0] : 5'd0;
    wctrl.stop   = run_last ? diff[5:0] : 6'd32;
    if (is_range) begin
      finish = run_last;
    end else begin
      finish = wres.hit || scan_last;
    end
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR: begin
        if (clr_last) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_acc) begin
          state_nxt = empty_c ? ST_DONE : ST_RUN;
        end
      end
      ST_RUN: begin
        if (finish) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid_r || !out_stall) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_CLEAR;
      end
    endcase
  end

  // State outputs: handshake and memory write port.
  always_comb begin
    in_stall  = 1'b1;
    out_load  = 1'b0;
    mem_we    = 1'b0;
    mem_waddr = AW'(cur_r);
    mem_wdata = wres.new_word;
    unique case (state_r)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_addr_r;
        mem_wdata = 32'd0;
      end
      ST_IDLE: begin
        in_stall = 1'b0;
      end
      ST_RUN: begin
        mem_we = is_range;
      end
      ST_DONE: begin
        out_load = !out_valid_r || !out_stall;
      end
      default: begin
        in_stall = 1'b1;
      end
    endcase
  end

  // Request registers. The next word is read in the same cycle as the current
  // one is written; the two share an entry only on the last word of a run.
  always_comb begin
    kind_nxt   = kind_r;
    start_nxt  = start_r;
    end_nxt    = end_r;
    nwords_nxt = nwords_r;
    cur_nxt    = cur_r;
    first_nxt  = first_r;
    res_nxt    = res_r;
    if (in_acc) begin
      kind_nxt   = in_data.req_type;
      start_nxt  = in_data.start_bit;
      end_nxt    = end_c;
      nwords_nxt = nwords_c;
      cur_nxt    = {1'b0, in_data.start_bit[14:5]};
      first_nxt  = 1'b1;
      res_nxt    = '0;
    end else if (state_r == ST_RUN) begin
      first_nxt = 1'b0;
      if (!finish) begin
        cur_nxt = cur_r + 11'd1;
      end else if (is_range) begin
        res_nxt.bits_changed = end_r - {1'b0, start_r};
      end else if (wres.hit) begin
        res_nxt.found        = 1'b1;
        res_nxt.bit_position = {cur_r[9:0], wres.lead};
      end
    end
  end

  assign rd_addr = AW'(cur_nxt);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_addr_r  <= '0;
      region_r    <= 11'd1024;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_CLEAR) begin
        clr_addr_r <= clr_addr_r + AW'(1);
      end
      if (cfg_valid && cfg_ready) begin
        region_r <= cfg_data;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    kind_r   <= kind_nxt;
    start_r  <= start_nxt;
    end_r    <= end_nxt;
    nwords_r <= nwords_nxt;
    cur_r    <= cur_nxt;
    first_r  <= first_nxt;
    res_r    <= res_nxt;
    if (out_load) begin
      out_data_r <= res_r;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
  end

  always_ff @(posedge clk) begin
    rd_data_r <= mem[rd_addr];
  end

`ifndef SYNTH
  // An accepted item either walks the store or goes straight to its result.
  a_accept_next: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> (state_r == ST_RUN) || (state_r == ST_DONE))
    else $error("accepted item did not enter the walk or done state");

  // Writes during a walk stay inside the region in use.
  a_write_in_region: assert property (@(posedge clk) disable iff (!rst_n)
    (mem_we && (state_r == ST_RUN)) |-> (cur_r < nwords_r))
    else $error("bitmap write outside the region");

  // A result never reports both a found bit and changed bits.
  a_result_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(out_data_r.found && (out_data_r.bits_changed != 16'd0)))
    else $error("result mixes find and range fields");
`endif

endmodule
`default_nettype wire

### sim/bitmap_find_set_clear_engine_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bitmap find / set / clear engine testbench
// Drives request items with random gaps against random result back-pressure,
// keeps a shadow copy of the allocation bitmap and checks every result item
// in order, over a range of region sizes from empty to oversized.
// ----------------------------------------------------------------------------
module bitmap_find_set_clear_engine_test;
  import bfsc_pkg::*;

  localparam int MAP_WORDS   = 1024;
  localparam int HOLD_CYCLES = 300;
  localparam int PHASES      = 10;
  localparam int DRAIN_LIMIT = 5000;

  typedef struct {
    bit          region_write;
    logic [10:0] region;
    bfsc_in_t    req;
    bit          typed;
    bfsc_out_t   answer;
  } probe_row_t;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  bfsc_in_t    in_data;
  logic        out_valid;
  logic        out_stall;
  bfsc_out_t   out_data;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [10:0] cfg_data;

  // Shadow of the engine: bitmap words and the region register.
  logic [31:0] shadow_map [MAP_WORDS];
  logic [10:0] shadow_region;

  bfsc_out_t   due_answers [$];
  probe_row_t  probe_rows [$];

  bit quiet        = 1'b0;
  bit hold_req     = 1'b0;
  int failures     = 0;
  int answers_seen = 0;
  int finds_hit    = 0;
  int bits_written = 0;
  int regions_used = 0;

  bitmap_find_set_clear_engine #(
    .BITMAP_WORDS(MAP_WORDS)
  ) uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data (cfg_data)
  );

  initial begin : clock_gen
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Works out the result of one request and applies any set or clear run to
  // the shadow bitmap. Bit k lives in word k/32 at position 31-(k%32).
  function automatic bfsc_out_t alloc_answer(bfsc_in_t req);
    int unsigned nwords;
    int unsigned total;
    int unsigned w;
    int unsigned b;
    int unsigned last;
    int unsigned lead;
    int unsigned off;
    logic [31:0] scan;
    bfsc_out_t   res;
    res    = '0;
    nwords = int'(shadow_region);
    if (nwords > MAP_WORDS) nwords = MAP_WORDS;
    total = nwords * 32;
    if (req.start_bit < total) begin
      if (req.req_type == REQ_FIND_SET || req.req_type == REQ_FIND_ZERO) begin
        off = int'(req.start_bit[4:0]);
        for (w = int'(req.start_bit[14:5]); w < nwords && !res.found; w++) begin
          scan = shadow_map[w[9:0]];
          if (req.req_type == REQ_FIND_ZERO) scan = ~scan;
          scan = scan & (ALL_ONES >> off);
          off  = 0;
          if (scan != '0) begin
            lead = 0;
            while (!scan[31 - lead]) lead++;
            res.found        = 1'b1;
            res.bit_position = 15'(w * 32 + lead);
          end
        end
      end else if (req.bit_count != '0) begin
        last = int'(req.start_bit) + int'(req.bit_count);
        if (last > total) last = total;
        res.bits_changed = 16'(last - int'(req.start_bit));
        for (b = int'(req.start_bit); b < last; b++) begin
          shadow_map[b[14:5]][~b[4:0]] = (req.req_type == REQ_SET_RANGE);
        end
      end
    end
    return res;
  endfunction

  // Mostly starts inside the region and short runs, with edges, starts past
  // the region, zero counts and full-width values mixed in.
  function automatic bfsc_in_t random_request(int unsigned nbits);
    bfsc_in_t    req;
    int unsigned roll;
    roll = $urandom_range(0, 9);
    if (roll < 2) begin
      req.req_type = REQ_FIND_SET;
    end else if (roll < 4) begin
      req.req_type = REQ_FIND_ZERO;
    end else if (roll < 7) begin
      req.req_type = REQ_SET_RANGE;
    end else begin
      req.req_type = REQ_CLEAR_RANGE;
    end
    roll = $urandom_range(0, 19);
    if (roll == 0 || nbits == 0) begin
      req.start_bit = 15'($urandom);
    end else if (roll == 1) begin
      req.start_bit = 15'(nbits - 1);
    end else if (roll == 2) begin
      req.start_bit = 15'(nbits);
    end else begin
      req.start_bit = 15'($urandom_range(0, nbits - 1));
    end
    roll = $urandom_range(0, 9);
    case (roll)
      0: begin
        req.bit_count = '0;
      end
      1: begin
        req.bit_count = 16'($urandom);
      end
      2: begin
        req.bit_count = 16'(nbits - int'(req.start_bit));
      end
      3: begin
        req.bit_count = 16'h8000;
      end
      default: begin
        req.bit_count = 16'($urandom_range(1, 96));
      end
    endcase
    return req;
  endfunction

  function automatic probe_row_t probe_free(bfsc_req_t kind, int unsigned start,
                                            int unsigned count);
    probe_row_t r;
    r.region_write      = 1'b0;
    r.region            = '0;
    r.req.req_type      = kind;
    r.req.start_bit     = 15'(start);
    r.req.bit_count     = 16'(count);
    r.typed             = 1'b0;
    r.answer            = '0;
    return r;
  endfunction

  function automatic probe_row_t probe(bfsc_req_t kind, int unsigned start, int unsigned count,
                                       bit hit, int unsigned pos, int unsigned changed);
    probe_row_t r;
    r                     = probe_free(kind, start, count);
    r.typed               = 1'b1;
    r.answer.found        = hit;
    r.answer.bit_position = 15'(pos);
    r.answer.bits_changed = 16'(changed);
    return r;
  endfunction

  function automatic probe_row_t region_step(logic [10:0] value);
    probe_row_t r;
    r              = probe_free(REQ_FIND_SET, 0, 0);
    r.region_write = 1'b1;
    r.region       = value;
    return r;
  endfunction

  // Called at a clock edge; returns at the edge that accepted the item.
  task automatic offer(bfsc_in_t req, bit typed, bfsc_out_t answer);
    bfsc_out_t predicted;
    if (!quiet && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= req;
    do @(posedge clk); while (in_stall);
    predicted = alloc_answer(req);
    due_answers.push_back(typed ? answer : predicted);
  endtask

  // Waits for every outstanding result, then lets the engine return to idle.
  task automatic settle();
    int waited;
    waited = 0;
    in_valid <= 1'b0;
    while (due_answers.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (4) @(posedge clk);
  endtask

  task automatic write_region(logic [10:0] value);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    shadow_region = value;
    regions_used++;
    cfg_valid <= 1'b0;
  endtask

  initial begin : receiver
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        // Long hold-off so that the engine fills up and stalls its input.
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        out_stall <= 1'b0;
        hold_req = 1'b0;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 4)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin : answer_check
    bfsc_out_t want;
    if (rst_n && out_valid && !out_stall) begin
      answers_seen++;
      if (out_data.found) finds_hit++;
      bits_written += int'(out_data.bits_changed);
      if (due_answers.size() == 0) begin
        $error("unexpected result: found %0b position %0d changed %0d",
               out_data.found, out_data.bit_position, out_data.bits_changed);
        failures++;
      end else begin
        want = due_answers.pop_front();
        if (out_data.found !== want.found) begin
          $error("found: expected %0b, got %0b", want.found, out_data.found);
          failures++;
        end
        if (out_data.bit_position !== want.bit_position) begin
          $error("bit_position: expected %0d, got %0d", want.bit_position,
                 out_data.bit_position);
          failures++;
        end
        if (out_data.bits_changed !== want.bits_changed) begin
          $error("bits_changed: expected %0d, got %0d", want.bits_changed,
                 out_data.bits_changed);
          failures++;
        end
      end
    end
  end

  initial begin : stimulus
    logic [10:0] region_plan [PHASES];
    int unsigned nwords;
    int          p;
    int          k;
    int          reps;

    rst_n     <= 1'b0;
    in_valid  <= 1'b0;
    in_data   <= '0;
    cfg_valid <= 1'b0;
    cfg_data  <= '0;
    shadow_region = 11'd1024;
    for (k = 0; k < MAP_WORDS; k++) shadow_map[k] = '0;

    // Directed table. Expected results are typed in where they are obvious.
    probe_rows.push_back(probe(REQ_FIND_SET, 0, 0, 1'b0, 0, 0));
    probe_rows.push_back(probe(REQ_FIND_ZERO, 0, 0, 1'b1, 0, 0));
    probe_rows.push_back(probe(REQ_FIND_ZERO, 32767, 0, 1'b1, 32767, 0));
    probe_rows.push_back(probe(REQ_SET_RANGE, 0, 0, 1'b0, 0, 0));
    probe_rows.push_back(probe(REQ_SET_RANGE, 32767, 65535, 1'b0, 0, 1));
    probe_rows.push_back(probe(REQ_FIND_SET, 0, 0, 1'b1, 32767, 0));
    probe_rows.push_back(probe(REQ_SET_RANGE, 5, 40, 1'b0, 0, 40));
    probe_rows.push_back(probe(REQ_FIND_SET, 0, 0, 1'b1, 5, 0));
    probe_rows.push_back(probe(REQ_FIND_ZERO, 5, 0, 1'b1, 45, 0));
    probe_rows.push_back(probe(REQ_CLEAR_RANGE, 10, 3, 1'b0, 0, 3));
    // The count is ignored on a find.
    probe_rows.push_back(probe_free(REQ_FIND_ZERO, 6, 65535));
    probe_rows.push_back(probe(REQ_SET_RANGE, 0, 32768, 1'b0, 0, 32768));
    probe_rows.push_back(probe(REQ_FIND_ZERO, 0, 0, 1'b0, 0, 0));
    probe_rows.push_back(probe(REQ_CLEAR_RANGE, 100, 1, 1'b0, 0, 1));
    probe_rows.push_back(probe(REQ_FIND_ZERO, 31, 0, 1'b1, 100, 0));
    // An oversized region behaves as the full store.
    probe_rows.push_back(region_step(11'd2047));
    probe_rows.push_back(probe(REQ_FIND_ZERO, 101, 0, 1'b0, 0, 0));
    probe_rows.push_back(region_step(11'd1));
    probe_rows.push_back(probe(REQ_FIND_ZERO, 0, 0, 1'b0, 0, 0));
    probe_rows.push_back(probe(REQ_SET_RANGE, 31, 5, 1'b0, 0, 1));
    probe_rows.push_back(probe(REQ_CLEAR_RANGE, 0, 16, 1'b0, 0, 16));
    probe_rows.push_back(probe(REQ_FIND_SET, 0, 0, 1'b1, 16, 0));
    probe_rows.push_back(probe(REQ_FIND_SET, 32, 0, 1'b0, 0, 0));
    probe_rows.push_back(probe(REQ_CLEAR_RANGE, 32, 10, 1'b0, 0, 0));
    // An empty region holds no bits at all.
    probe_rows.push_back(region_step(11'd0));
    probe_rows.push_back(probe(REQ_FIND_ZERO, 0, 0, 1'b0, 0, 0));
    probe_rows.push_back(probe(REQ_SET_RANGE, 0, 5, 1'b0, 0, 0));
    probe_rows.push_back(region_step(11'd3));
    probe_rows.push_back(probe(REQ_CLEAR_RANGE, 0, 96, 1'b0, 0, 96));
    probe_rows.push_back(probe_free(REQ_SET_RANGE, 40, 9));
    probe_rows.push_back(probe_free(REQ_FIND_SET, 2, 0));

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    for (k = 0; k < probe_rows.size(); k++) begin
      if (probe_rows[k].region_write) begin
        settle();
        write_region(probe_rows[k].region);
      end else begin
        offer(probe_rows[k].req, probe_rows[k].typed, probe_rows[k].answer);
      end
    end

    // Random phases; the large regions are few so that long scans stay rare.
    region_plan = '{11'd1, 11'd2047, 11'd0, 11'd32, 11'd0,
                    11'd1023, 11'd0, 11'd1024, 11'd5, 11'd0};
    region_plan[2] = 11'($urandom_range(2, 64));
    region_plan[6] = 11'($urandom_range(65, 200));
    region_plan[9] = 11'($urandom_range(2, 16));
    for (p = 0; p < PHASES; p++) begin
      settle();
      write_region(region_plan[p]);
      nwords = int'(region_plan[p]);
      if (nwords > MAP_WORDS) nwords = MAP_WORDS;
      if (p == 3) hold_req = 1'b1;
      if (p == PHASES - 1) quiet = 1'b1;
      reps = (nwords == 0) ? 40 : 130;
      for (k = 0; k < reps; k++) begin
        offer(random_request(nwords * 32), 1'b0, '0);
      end
    end

    settle();
    repeat (20) @(posedge clk);
    if (due_answers.size() != 0) begin
      $error("%0d expected results never arrived", due_answers.size());
      failures++;
    end
    $display("Checked %0d results across %0d region settings, empty to oversized.",
             answers_seen, regions_used);
    $display("Finds that hit: %0d, bits written by set and clear runs: %0d.",
             finds_hit, bits_written);
    if (failures == 0) begin
      $display("bitmap_find_set_clear_engine test passed");
    end else begin
      $display("bitmap_find_set_clear_engine test failed");
    end
    $finish;
  end

  // A correct run needs well under 3 ms even if every item scanned the whole
  // store; this allows several times that.
  initial begin : watchdog
    #10_000_000;
    $display("bitmap_find_set_clear_engine test failed");
    $finish;
  end

endmodule
